@@ hw/rtl/return_address_shadow_monitor_core_defines.svh @@
// assertion macros shared by the shadow monitor rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef RETURN_ADDRESS_SHADOW_MONITOR_CORE_DEFINES_SVH
`define RETURN_ADDRESS_SHADOW_MONITOR_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// plain check every clock, off during reset
`define RASM_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// same-cycle implication
`define RASM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define RASM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RASM_ASSERT(lbl, expr, msg)
`define RASM_ASSERT_IMP(lbl, ante, cons, msg)
`define RASM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ hw/rtl/rasm_pkg.sv @@
// shared types, field widths and codes of the return address shadow monitor
// no dependencies
package rasm_pkg;

    localparam int ADDR_W   = 32;
    localparam int MODE_W   = 2;
    localparam int THREAD_W = 2;
    localparam int STATUS_W = 3;
    localparam int UNWOUND_W = 6;

    localparam int DEF_THREADS = 4;
    localparam int DEF_ENTRIES = 32;

    localparam logic [MODE_W-1:0] MODE_CALL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RET  = 2'd1;

    localparam logic [STATUS_W-1:0] ST_CALL_STORED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CALL_OVERFLOW = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RET_TOP       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RET_BELOW     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RET_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_PUSH_DISCARD  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_WRITE_CLEAN   = 3'd6;
    localparam logic [STATUS_W-1:0] ST_OVERWRITE     = 3'd7;

    // what a cell hands to its upper neighbor
    typedef struct packed {
        logic              lt;
        logic [ADDR_W-1:0] value;
    } rasm_link_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } rasm_state_t;

endpackage

@@ hw/rtl/rasm_if.sv @@
// valid/ready channel interfaces for monitor events and results
// depends on rasm_pkg
interface rasm_req_if;
    import rasm_pkg::*;
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [THREAD_W-1:0] thread;
    logic [ADDR_W-1:0]   address;
    logic                push_before;

    modport source (output valid, mode, thread, address, push_before, input ready);
    modport sink (input valid, mode, thread, address, push_before, output ready);
endinterface

interface rasm_rsp_if;
    import rasm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [UNWOUND_W-1:0] unwound;
    logic [ADDR_W-1:0]    lowest_entry;
    logic                 set_empty;

    modport source (output valid, status, unwound, lowest_entry, set_empty, input ready);
    modport sink (input valid, status, unwound, lowest_entry, set_empty, output ready);
endinterface

@@ hw/rtl/rasm_ram.sv @@
// generic single write port ram with one registered read port
// no dependencies
module rasm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/rasm_cell.sv @@
// one slot of the ring of shadow cells: per-thread storage, compare, shift-in
// depends on rasm_pkg and rasm_ram
module rasm_cell #(
    parameter int THREADS = 4,
    parameter int ENTRIES = 32,
    parameter int CELL_ID = 0
) (
    input  logic                                       clk,
    input  logic                                       rd_en,
    input  logic [(THREADS > 1 ? $clog2(THREADS) : 1)-1:0] rd_thread,
    input  logic [(THREADS > 1 ? $clog2(THREADS) : 1)-1:0] wr_thread,
    input  logic                                       ins_en,
    input  logic [$clog2(ENTRIES)-1:0]                 base,
    input  logic [$clog2(ENTRIES+1)-1:0]               cnt,
    input  logic [rasm_pkg::ADDR_W-1:0]                address,
    input  rasm_pkg::rasm_link_t                       link_prev,
    output rasm_pkg::rasm_link_t                       link_out,
    output logic                                       eq,
    output logic [$clog2(ENTRIES)-1:0]                 eq_pos,
    output logic [rasm_pkg::ADDR_W-1:0]                low_val
);
    import rasm_pkg::*;

    localparam int IDXW = $clog2(ENTRIES);
    localparam logic [IDXW+1:0] ENT_W = (IDXW+2)'(ENTRIES);
    localparam logic [IDXW+1:0] CID_W = (IDXW+2)'(CELL_ID);

    logic [ADDR_W-1:0] val;
    logic [IDXW+1:0]   diff;
    logic [IDXW-1:0]   j;
    logic              occ;
    logic              lt;
    logic              wr;
    logic [ADDR_W-1:0] wr_val;

    // logical slot of this cell relative to the thread's ring base
    always_comb
    begin
        diff = CID_W + ENT_W - {2'b00, base};
        if (diff >= ENT_W)
        begin
            diff = diff - ENT_W;
        end
    end
    assign j   = diff[IDXW-1:0];
    assign occ = 16'(j) < 16'(cnt);
    assign lt  = occ && (val < address);
    assign eq  = occ && (val == address);

    assign link_out.lt    = lt;
    assign link_out.value = val;
    assign eq_pos  = eq ? j : '0;
    assign low_val = (occ && (j == '0)) ? val : '0;

    // insert: the slot at the insert point takes the new address, slots above it take the lower neighbor's word
    assign wr     = ins_en && (16'(j) <= 16'(cnt)) && !lt;
    assign wr_val = ((j == '0) || link_prev.lt) ? address : link_prev.value;

    rasm_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (THREADS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr),
        .wr_addr (wr_thread),
        .wr_data (wr_val),
        .rd_en   (rd_en),
        .rd_addr (rd_thread),
        .rd_data (val)
    );

endmodule

@@ hw/rtl/return_address_shadow_monitor_core.sv @@
// return address shadow monitor: top level with the cell ring and thread control
// depends on rasm_pkg, rasm_if, rasm_ram, rasm_cell and the assertion macros
//
// Keeps, per thread, an ascending set of stack locations holding return
// addresses. Calls insert, returns unwind up to and including the matching
// location (or drop the lowest one when a push precedes the return), memory
// writes are checked for overwrites. Every accepted transfer on req gives
// exactly one transfer on rsp. On acceptance every cell's word for the
// thread is read into a register; in S_EXEC all cells compare at once and
// the update commits, and S_EXEC stretches while a previous result still sits
// in the rsp register. Each set lives in a ring of ENTRIES cells with a
// per-thread base and count, so unwinding moves only the base and count,
// not the words. Counts reset through per-thread valid bits, so the block
// is usable right after reset with no clearing pass.
`include "return_address_shadow_monitor_core_defines.svh"
module return_address_shadow_monitor_core #(
    parameter int THREADS = rasm_pkg::DEF_THREADS,
    parameter int ENTRIES = rasm_pkg::DEF_ENTRIES
) (
    input  logic          clk,
    input  logic          rst_n,
    rasm_req_if.sink      req,
    rasm_rsp_if.source    rsp
);
    import rasm_pkg::*;

    localparam int IDXW  = $clog2(ENTRIES);
    localparam int CNTW  = $clog2(ENTRIES + 1);
    localparam int TW    = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int METAW = IDXW + CNTW;
    localparam logic [IDXW+1:0] ENT_W = (IDXW+2)'(ENTRIES);
    localparam logic [CNTW-1:0] ENT_C = CNTW'(ENTRIES);

    // thread field folded into range
    function automatic logic [TW-1:0] fold_thread(input logic [THREAD_W-1:0] th);
        logic [7:0] v;
        v = 8'(th);
        for (int s = 0; s < 4; s++)
        begin
            if (v >= 8'(THREADS))
            begin
                v = v - 8'(THREADS);
            end
        end
        return v[TW-1:0];
    endfunction

    rasm_state_t        state_reg, state_next;
    logic [MODE_W-1:0]  mode_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               push_reg;
    logic [TW-1:0]      thr_reg;
    logic [THREADS-1:0] meta_vld_reg, meta_vld_next;

    logic                 rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [UNWOUND_W-1:0] unwound_reg, unwound_next;
    logic [ADDR_W-1:0]    lowest_reg;
    logic                 empty_reg;

    logic            accept;
    logic            exec;
    logic            commit;
    logic [TW-1:0]   thr_in;
    logic [METAW-1:0] meta_rd;
    logic [METAW-1:0] meta_wr;
    logic [IDXW-1:0] cur_base;
    logic [CNTW-1:0] cur_cnt;
    logic [IDXW-1:0] base_next;
    logic [CNTW-1:0] cnt_next;

    // cell ring
    rasm_link_t        link [ENTRIES];
    logic [ENTRIES-1:0] eq_vec;
    logic [IDXW-1:0]   eq_pos [ENTRIES];
    logic [ADDR_W-1:0] low_val [ENTRIES];

    logic              hit;
    logic [IDXW-1:0]   pos;
    logic [ADDR_W-1:0] lowest;
    logic              empty;
    logic              full;
    logic              do_insert;
    logic              ins_en;
    logic [15:0]       drop;
    logic [IDXW+1:0]   base_sum;

    assign exec   = (state_reg == S_EXEC);
    assign accept = req.valid && req.ready;
    assign commit = exec && (!rsp_valid_reg || rsp.ready);
    assign thr_in = fold_thread(req.thread);

    assign req.ready = (state_reg == S_IDLE);

    // per-thread base and count; a thread never written reads as empty
    rasm_ram #(
        .WIDTH (METAW),
        .DEPTH (THREADS)
    ) u_meta (
        .clk     (clk),
        .wr_en   (commit),
        .wr_addr (thr_reg),
        .wr_data (meta_wr),
        .rd_en   (accept),
        .rd_addr (thr_in),
        .rd_data (meta_rd)
    );

    assign cur_base = meta_vld_reg[thr_reg] ? meta_rd[METAW-1:CNTW] : '0;
    assign cur_cnt  = meta_vld_reg[thr_reg] ? meta_rd[CNTW-1:0] : '0;
    assign meta_wr  = {base_next, cnt_next};

    assign ins_en = commit && do_insert;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        localparam int PREV = (i == 0) ? ENTRIES - 1 : i - 1;
        rasm_cell #(
            .THREADS (THREADS),
            .ENTRIES (ENTRIES),
            .CELL_ID (i)
        ) u_cell (
            .clk       (clk),
            .rd_en     (accept),
            .rd_thread (thr_in),
            .wr_thread (thr_reg),
            .ins_en    (ins_en),
            .base      (cur_base),
            .cnt       (cur_cnt),
            .address   (addr_reg),
            .link_prev (link[PREV]),
            .link_out  (link[i]),
            .eq        (eq_vec[i]),
            .eq_pos    (eq_pos[i]),
            .low_val   (low_val[i])
        );
    end

    // at most one cell matches, so the match slot and the lowest word or together
    always_comb
    begin
        pos    = '0;
        lowest = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            pos    = pos | eq_pos[i];
            lowest = lowest | low_val[i];
        end
    end

    assign hit   = |eq_vec;
    assign empty = (cur_cnt == '0);
    assign full  = (cur_cnt >= ENT_C);

    // decode the event and the new ring base and count
    always_comb
    begin
        do_insert    = 1'b0;
        drop         = 16'd0;
        unwound_next = '0;
        if (mode_reg == MODE_CALL)
        begin
            do_insert   = !hit && !full;
            status_next = (hit || !full) ? ST_CALL_STORED : ST_CALL_OVERFLOW;
        end
        else if (mode_reg == MODE_RET)
        begin
            priority if (push_reg)
            begin
                status_next = ST_PUSH_DISCARD;
                drop        = empty ? 16'd0 : 16'd1;
            end
            else if (!hit)
            begin
                status_next = ST_RET_NOT_FOUND;
            end
            else
            begin
                status_next  = (pos == '0) ? ST_RET_TOP : ST_RET_BELOW;
                drop         = 16'(pos) + 16'd1;
                unwound_next = drop[UNWOUND_W-1:0];
            end
        end
        else
        begin
            status_next = hit ? ST_OVERWRITE : ST_WRITE_CLEAN;
        end
    end

    // unwinding moves the ring base up by the dropped count
    always_comb
    begin
        base_sum = {2'b00, cur_base} + drop[IDXW+1:0];
        if (base_sum >= ENT_W)
        begin
            base_sum = base_sum - ENT_W;
        end
    end
    assign base_next = base_sum[IDXW-1:0];
    assign cnt_next  = do_insert ? cur_cnt + CNTW'(1) : cur_cnt - drop[CNTW-1:0];

    always_comb
    begin
        state_next    = state_reg;
        meta_vld_next = meta_vld_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    state_next             = S_IDLE;
                    meta_vld_next[thr_reg] = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register frees its slot on a transfer
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            meta_vld_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            meta_vld_reg  <= meta_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= req.mode;
            addr_reg <= req.address;
            push_reg <= req.push_before;
            thr_reg  <= thr_in;
        end
        if (commit)
        begin
            status_reg  <= status_next;
            unwound_reg <= unwound_next;
            lowest_reg  <= lowest;
            empty_reg   <= empty;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.unwound      = unwound_reg;
    assign rsp.lowest_entry = lowest_reg;
    assign rsp.set_empty    = empty_reg;

    `RASM_ASSERT_IMP(a_cnt_range, exec, cur_cnt <= ENT_C, "shadow set count beyond capacity")
    `RASM_ASSERT_IMP(a_one_match, exec, $onehot0(eq_vec), "more than one cell matched")
    `RASM_ASSERT_IMP(a_ins_room, ins_en, cur_cnt < ENT_C, "insert into a full set")
    `RASM_ASSERT_IMP(a_no_clobber, commit, !rsp_valid_reg || rsp.ready,
        "result overwritten before transfer")
    `RASM_ASSERT_NXT(a_accept_exec, accept, exec, "accepted item did not start work")

endmodule
